### design/tetab_pkg.sv
// shared types, widths and codes for the top-energy solution table
package tetab_pkg;

  // fixed field widths
  localparam int KEY_W   = 48;
  localparam int HIT_W   = 16;
  localparam int SOL_W   = 64;
  localparam int ABITS_W = 7;
  localparam int RES_W   = 5;

  // parameter defaults
  localparam int ENTRIES_DEF       = 16;
  localparam int SOLUTION_BITS_DEF = 64;

  // register reset value
  localparam logic [ABITS_W-1:0] ABITS_RESET = 7'd64;

  // result codes
  typedef enum logic [2:0] {
    OUT_NOTHING     = 3'd0,
    OUT_NEW_BEST    = 3'd1,
    OUT_NEW_UNIQUE  = 3'd2,
    OUT_DUP_BEST    = 3'd3,
    OUT_DUP         = 3'd4,
    OUT_UNIQUE_SAME = 3'd5
  } outcome_t;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // running scan summary handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] best;
    logic [KEY_W-1:0] worst;
    logic             found;
    logic             anyeq;
    logic [HIT_W-1:0] match_hit;
  } acc_t;

  // write-back command broadcast to all cells
  typedef struct packed {
    logic load;
    logic bump;
  } wr_t;

endpackage

### design/tetab_cell.sv
// one table slot: holds an entry and folds it into the passing scan summary
module tetab_cell #(
  parameter int ENTRIES       = 16,
  parameter int SOLUTION_BITS = 64,
  parameter int IDX           = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [tetab_pkg::KEY_W-1:0]            cand_key,
  input  logic [SOLUTION_BITS-1:0]               cand_sol,
  input  logic [SOLUTION_BITS-1:0]               mask,
  input  tetab_pkg::acc_t                        acc_in,
  input  logic [$clog2(ENTRIES)-1:0]             victim_in,
  input  logic [$clog2(ENTRIES)-1:0]             match_in,
  input  logic [$clog2(ENTRIES+1)-1:0]           rank_in,
  output tetab_pkg::acc_t                        acc_out,
  output logic [$clog2(ENTRIES)-1:0]             victim_out,
  output logic [$clog2(ENTRIES)-1:0]             match_out,
  output logic [$clog2(ENTRIES+1)-1:0]           rank_out,
  input  tetab_pkg::wr_t                         wr,
  input  logic [$clog2(ENTRIES)-1:0]             wr_idx
);
  import tetab_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [KEY_W-1:0]         key;
  logic [SOLUTION_BITS-1:0] sol;
  logic [HIT_W-1:0]         hit;

  acc_t          acc_next;
  logic [IW-1:0] victim_next;
  logic [IW-1:0] match_next;
  logic [CW-1:0] rank_next;
  logic          key_eq;
  logic          sol_eq;
  logic          sel;

  // fold this slot into the summary
  always_comb begin
    key_eq      = (key == cand_key);
    sol_eq      = (((sol ^ cand_sol) & mask) == '0);
    acc_next    = acc_in;
    victim_next = victim_in;
    match_next  = match_in;
    rank_next   = rank_in + CW'(key > cand_key);
    if (key > acc_in.best) begin
      acc_next.best = key;
    end
    if (key < acc_in.worst) begin
      acc_next.worst = key;
      victim_next    = MY_IDX;
    end
    if (key_eq) begin
      acc_next.anyeq = 1'b1;
    end
    if (key_eq && sol_eq && !acc_in.found) begin
      acc_next.found     = 1'b1;
      acc_next.match_hit = hit;
      match_next         = MY_IDX;
    end
  end

  // summary stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.valid <= 1'b0;
    end else begin
      acc_out.valid <= acc_next.valid;
    end
    acc_out.best      <= acc_next.best;
    acc_out.worst     <= acc_next.worst;
    acc_out.found     <= acc_next.found;
    acc_out.anyeq     <= acc_next.anyeq;
    acc_out.match_hit <= acc_next.match_hit;
    victim_out        <= victim_next;
    match_out         <= match_next;
    rank_out          <= rank_next;
  end

  // slot contents, written back by the broadcast command
  assign sel = (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      sol <= '0;
      hit <= '0;
    end else if (wr.load && sel) begin
      key <= cand_key;
      sol <= cand_sol;
      hit <= HIT_W'(1);
    end else if (wr.bump && sel) begin
      if (hit != '1) begin
        hit <= hit + HIT_W'(1);
      end
    end
  end

endmodule

### design/top_energy_solution_table_top.sv
// top level: candidate capture, chain of slot cells, decision and result register
// the start beat passes the launch register, the summary register of each cell, then done
// one item at a time, no start taken mid-scan; the summary walks one cell per cycle
// busy spans the scan only; done is a one-cycle strobe the receiver cannot stall
// rst (synchronous) empties the table, zeroes the count and sets active_bits to 64
module top_energy_solution_table_top #(
  parameter int ENTRIES       = tetab_pkg::ENTRIES_DEF,
  parameter int SOLUTION_BITS = tetab_pkg::SOLUTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tetab_pkg::KEY_W-1:0] energy,
  input  logic [tetab_pkg::SOL_W-1:0]       solution,
  output logic                              done,
  output logic [2:0]                        outcome,
  output logic [tetab_pkg::HIT_W-1:0]       hit_count,
  output logic [tetab_pkg::RES_W-1:0]       rank_position,
  output logic [tetab_pkg::RES_W-1:0]       stored_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tetab_pkg::ABITS_W-1:0]     cfg_data
);
  import tetab_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  state_t state;
  state_t state_next;

  logic [ABITS_W-1:0]       active_bits;
  logic [ABITS_W-1:0]       nbits;
  logic [SOLUTION_BITS-1:0] mask;
  logic [KEY_W-1:0]         cand_key;
  logic [SOLUTION_BITS-1:0] cand_sol;
  logic                     launch;
  logic [CW-1:0]            stored;
  logic [CW-1:0]            stored_next;
  logic                     accept;

  acc_t          acc_link    [ENTRIES+1];
  logic [IW-1:0] victim_link [ENTRIES+1];
  logic [IW-1:0] match_link  [ENTRIES+1];
  logic [CW-1:0] rank_link   [ENTRIES+1];

  acc_t          acc_end;
  logic          finish;
  wr_t           wr;
  logic [IW-1:0] wr_idx;
  outcome_t      res_outcome;
  logic [HIT_W-1:0] res_count;

  assign accept = start && !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= ABITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_bits <= cfg_data;
    end
  end

  // active solution bits: zero acts as one, widths past the store are moot
  assign nbits = (active_bits == '0) ? ABITS_W'(1) : active_bits;

  always_comb begin
    for (int j = 0; j < SOLUTION_BITS; j++) begin
      mask[j] = (ABITS_W'(j) < nbits);
    end
  end

  // candidate capture, energy kept as offset-binary key
  always_ff @(posedge clk) begin
    if (accept) begin
      cand_key <= {~energy[KEY_W-1], energy[KEY_W-2:0]};
      cand_sol <= solution[SOLUTION_BITS-1:0] & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (acc_end.valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    cfg_ready = 1'b0;
    finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // a start beat takes the cycle, the width write waits
        cfg_ready = !start;
      end
      ST_SCAN: begin
        busy   = 1'b1;
        finish = acc_end.valid;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // head of the chain: empty summary
  assign acc_link[0] = '{valid: launch, best: '0, worst: '1, found: 1'b0, anyeq: 1'b0,
                         match_hit: '0};
  assign victim_link[0] = '0;
  assign match_link[0]  = '0;
  assign rank_link[0]   = '0;

  // row of slot cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tetab_cell #(
      .ENTRIES       (ENTRIES),
      .SOLUTION_BITS (SOLUTION_BITS),
      .IDX           (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cand_key   (cand_key),
      .cand_sol   (cand_sol),
      .mask       (mask),
      .acc_in     (acc_link[g]),
      .victim_in  (victim_link[g]),
      .match_in   (match_link[g]),
      .rank_in    (rank_link[g]),
      .acc_out    (acc_link[g+1]),
      .victim_out (victim_link[g+1]),
      .match_out  (match_link[g+1]),
      .rank_out   (rank_link[g+1]),
      .wr         (wr),
      .wr_idx     (wr_idx)
    );
  end

  assign acc_end = acc_link[ENTRIES];

  // decision on the finished summary
  always_comb begin
    wr.load     = 1'b0;
    wr.bump     = 1'b0;
    wr_idx      = victim_link[ENTRIES];
    res_outcome = OUT_NOTHING;
    res_count   = '0;
    if (cand_key > acc_end.best) begin
      wr.load     = finish;
      res_outcome = OUT_NEW_BEST;
      res_count   = HIT_W'(1);
    end else if (cand_key < acc_end.worst) begin
      res_outcome = OUT_NOTHING;
    end else if (acc_end.found) begin
      wr.bump     = finish;
      wr_idx      = match_link[ENTRIES];
      res_count   = (acc_end.match_hit == '1) ? acc_end.match_hit
                                              : acc_end.match_hit + HIT_W'(1);
      res_outcome = (cand_key == acc_end.best) ? OUT_DUP_BEST : OUT_DUP;
    end else begin
      wr.load   = finish;
      res_count = HIT_W'(1);
      if (!acc_end.anyeq) begin
        res_outcome = OUT_NEW_UNIQUE;
      end else if (cand_key == acc_end.best) begin
        res_outcome = OUT_DUP_BEST;
      end else begin
        res_outcome = OUT_UNIQUE_SAME;
      end
    end
  end

  // stored-entry count, saturating at the table size
  assign stored_next = (wr.load && stored < CW'(ENTRIES)) ? stored + CW'(1) : stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else begin
      stored <= stored_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
    if (finish) begin
      outcome       <= res_outcome;
      hit_count     <= res_count;
      rank_position <= RES_W'(rank_link[ENTRIES]);
      stored_total  <= RES_W'(stored_next);
    end
  end

`ifndef SYNTH
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(finish))
    else $error("result strobe without a finished scan");

  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CW'(ENTRIES))
    else $error("stored count past table size");

  a_nothing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == OUT_NOTHING) |-> hit_count == '0)
    else $error("hit count nonzero on empty outcome");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(wr.load && wr.bump))
    else $error("load and bump in the same beat");
`endif

endmodule

### sim/top_energy_solution_table_top_tb.sv
// self-checking testbench for the top-energy solution table
module top_energy_solution_table_top_tb;
  import tetab_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int RESULT_LAT  = ENTRIES + 2;
  localparam int QUIET_LIMIT = 400;
  localparam int PHASE_ITEMS = 118;

  localparam logic signed [KEY_W-1:0] E_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [KEY_W-1:0] E_MIN  = 48'sh8000_0000_0000;
  localparam logic signed [KEY_W-1:0] E_ONE  = 48'sh0000_0001_0000;
  localparam logic signed [KEY_W-1:0] E_NEG1 = 48'shFFFF_FFFF_FFFF;

  // what the driver works through: candidates, width writes, settle points
  typedef enum logic [1:0] {
    REQ_CAND,
    REQ_WIDTH,
    REQ_SETTLE
  } req_kind_t;

  typedef struct {
    req_kind_t               kind;
    logic signed [KEY_W-1:0] energy;
    logic [SOL_W-1:0]        sol;
    logic [ABITS_W-1:0]      width;
    int                      gap;
    bit                      gap_any;
  } req_t;

  typedef struct {
    outcome_t           outcome;
    logic [HIT_W-1:0]   hits;
    logic [RES_W-1:0]   rank;
    logic [RES_W-1:0]   total;
  } table_res_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [KEY_W-1:0] energy = '0;
  logic [SOL_W-1:0]        solution = '0;
  logic                    done;
  logic [2:0]              outcome;
  logic [HIT_W-1:0]        hit_count;
  logic [RES_W-1:0]        rank_position;
  logic [RES_W-1:0]        stored_total;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [ABITS_W-1:0]      cfg_data = '0;

  // shadow copy of the table
  logic signed [KEY_W-1:0] tbl_energy [ENTRIES];
  logic [SOL_W-1:0]        tbl_sol [ENTRIES];
  logic [HIT_W-1:0]        tbl_hits [ENTRIES];
  int                      tbl_count = 0;
  logic [ABITS_W-1:0]      tbl_width = ABITS_RESET;

  req_t       req_q[$];
  table_res_t pending_results[$];

  int  cand_sent = 0;
  int  cand_taken = 0;
  int  width_sent = 0;
  int  width_taken = 0;
  int  hold_left = 0;
  bit  armed = 1'b0;
  bit  stim_done = 1'b0;
  bit  burst_mode = 1'b0;
  int  err_cnt = 0;
  int  quiet_cycles = 0;

  top_energy_solution_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .energy        (energy),
    .solution      (solution),
    .done          (done),
    .outcome       (outcome),
    .hit_count     (hit_count),
    .rank_position (rank_position),
    .stored_total  (stored_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // overwrite one slot with a fresh entry
  function automatic void table_put(int idx, logic signed [KEY_W-1:0] e,
                                    logic [SOL_W-1:0] s);
    tbl_energy[idx] = e;
    tbl_sol[idx] = s;
    tbl_hits[idx] = 16'd1;
    if (tbl_count < ENTRIES) tbl_count++;
  endfunction

  // apply one candidate to the shadow table and return the expected result
  function automatic table_res_t table_insert(logic signed [KEY_W-1:0] e,
                                              logic [SOL_W-1:0] s_in);
    logic [SOL_W-1:0]        m;
    logic [SOL_W-1:0]        s;
    logic signed [KEY_W-1:0] best;
    logic signed [KEY_W-1:0] worst;
    int                      victim;
    int                      slot;
    int                      n;
    int                      above;
    bit                      hit;
    bit                      same_e;
    table_res_t              r;
    n = int'(tbl_width);
    if (n < 1) n = 1;
    if (n > SOL_W) n = SOL_W;
    m = (n == SOL_W) ? '1 : ((64'd1 << n) - 64'd1);
    s = s_in & m;
    best = tbl_energy[0];
    worst = tbl_energy[0];
    victim = 0;
    slot = 0;
    hit = 1'b0;
    same_e = 1'b0;
    above = 0;
    r.hits = '0;
    // best, worst and lowest slot holding the worst
    for (int i = 1; i < ENTRIES; i++) begin
      if (tbl_energy[i] > best) best = tbl_energy[i];
      if (tbl_energy[i] < worst) begin
        worst = tbl_energy[i];
        victim = i;
      end
    end
    if (e > best) begin
      table_put(victim, e, s);
      r.outcome = OUT_NEW_BEST;
      r.hits = 16'd1;
    end else if (e < worst) begin
      r.outcome = OUT_NOTHING;
    end else begin
      // lowest slot with equal energy and equal active bits
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_energy[i] == e) begin
          same_e = 1'b1;
          if (!hit && ((tbl_sol[i] ^ s) & m) == '0) begin
            hit = 1'b1;
            slot = i;
          end
        end
      end
      if (hit) begin
        if (tbl_hits[slot] != '1) tbl_hits[slot]++;
        r.hits = tbl_hits[slot];
        r.outcome = (e == best) ? OUT_DUP_BEST : OUT_DUP;
      end else begin
        table_put(victim, e, s);
        r.hits = 16'd1;
        if (same_e) r.outcome = (e == best) ? OUT_DUP_BEST : OUT_UNIQUE_SAME;
        else r.outcome = OUT_NEW_UNIQUE;
      end
    end
    // rank counted after the update
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_energy[i] > e) above++;
    end
    r.rank = above[RES_W-1:0];
    r.total = tbl_count[RES_W-1:0];
    return r;
  endfunction

  function automatic void add_cand(logic signed [KEY_W-1:0] e, logic [SOL_W-1:0] s);
    req_t q;
    q.kind = REQ_CAND;
    q.energy = e;
    q.sol = s;
    q.width = '0;
    q.gap = burst_mode ? 0 : int'($urandom_range(0, 10));
    q.gap_any = 1'($urandom_range(0, 1));
    req_q.push_back(q);
  endfunction

  function automatic void add_ctl(req_kind_t k, logic [ABITS_W-1:0] w);
    req_t q;
    q.kind = k;
    q.energy = '0;
    q.sol = '0;
    q.width = w;
    q.gap = 0;
    q.gap_any = 1'b0;
    req_q.push_back(q);
  endfunction

  // stimulus, reset and end of run
  initial begin
    logic signed [KEY_W-1:0] e_pool [24];
    logic [SOL_W-1:0]        s_pool [6];
    logic signed [KEY_W-1:0] e;
    logic [SOL_W-1:0]        s;
    logic [ABITS_W-1:0]      w;
    longint                  v;
    int                      eff;
    int                      roll;
    int                      pick;

    for (int i = 0; i < ENTRIES; i++) begin
      tbl_energy[i] = E_MIN;
      tbl_sol[i] = '0;
      tbl_hits[i] = '0;
    end

    // directed: sentinel match, extremes, every outcome, filling the table
    add_cand(E_MIN, 64'h0);
    add_cand(E_MIN, 64'h1);
    add_cand(E_MAX, '1);
    add_cand(E_MAX, '1);
    add_cand(E_MAX, 64'h5555_5555_5555_5555);
    add_cand('0, 64'h8000_0000_0000_0000);
    add_cand('0, 64'h8000_0000_0000_0000);
    add_cand('0, 64'hAAAA_AAAA_AAAA_AAAA);
    add_cand(E_NEG1, 64'h0000_0000_FFFF_FFFF);
    add_cand(E_ONE, 64'hFFFF_FFFF_0000_0000);
    for (int i = 2; i < 12; i++) add_cand(E_ONE * i, 64'h100 * i);
    add_cand(E_MIN, 64'h0);
    add_cand(-(E_ONE * 5), 64'h3);
    add_cand('0, 64'h7);

    // random phases, each under its own solution width
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: w = 7'd1;
        1: w = 7'd0;
        2: w = 7'd127;
        3: w = 7'd64;
        4: w = 7'd65;
        5: w = 7'd8;
        6: w = 7'($urandom_range(2, 63));
        7: w = 7'd33;
        8: w = 7'd16;
        default: w = 7'($urandom_range(0, 127));
      endcase
      add_ctl(REQ_WIDTH, w);
      eff = (w == 0) ? 1 : ((w > 64) ? 64 : int'(w));
      // energies climb from phase to phase so the table keeps turning over
      for (int k = 0; k < 24; k++) begin
        v = (longint'(ph) * 40 - 200 + longint'($urandom_range(0, 23))) * 65536
            + ($urandom_range(0, 1) ? 32768 : 0);
        e_pool[k] = v[KEY_W-1:0];
      end
      for (int k = 0; k < 6; k++) s_pool[k] = {$urandom, $urandom};
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if (k == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0) add_ctl(REQ_SETTLE, '0);
        roll = $urandom_range(0, 199);
        pick = $urandom_range(0, 23);
        if (roll < 2) e = KEY_W'({$urandom, $urandom});
        else if (roll < 6) e = E_MIN;
        else if (roll < 7) e = E_MAX;
        else if (roll < 10) e = $urandom_range(0, 1) ? E_NEG1 : '0;
        else if (roll < 40) e = {e_pool[pick][KEY_W-1:16], 16'($urandom)};
        else e = e_pool[pick];
        roll = $urandom_range(0, 9);
        pick = $urandom_range(0, 5);
        // pool vectors, pool vectors with masked-off bits disturbed, or noise
        if (roll < 5) s = s_pool[pick];
        else if (roll < 8) s = s_pool[pick] ^ ({$urandom, $urandom} << eff);
        else s = {$urandom, $urandom};
        add_cand(e, s);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_LAT + 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("top_energy_solution_table_top_tb: done, clean");
    end else begin
      $display("top_energy_solution_table_top_tb: done, errors");
    end
    $finish;
  end

  // driver: one beat at a time, width writes only with the table idle
  always @(negedge clk) begin
    if (!rst) begin
      if (start && cand_taken != cand_sent) begin
        // candidate still held off by busy
      end else if (cfg_valid && width_taken != width_sent) begin
        // width write still waiting for ready
      end else if (req_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        stim_done = 1'b1;
      end else begin
        case (req_q[0].kind)
          REQ_CAND: begin
            if (!armed) begin
              hold_left = req_q[0].gap;
              armed = 1'b1;
            end
            cfg_valid <= 1'b0;
            if (hold_left > 0) begin
              if (!busy || req_q[0].gap_any) hold_left--;
              start <= 1'b0;
            end else begin
              start <= 1'b1;
              energy <= req_q[0].energy;
              solution <= req_q[0].sol;
              cand_sent++;
              armed = 1'b0;
              req_q.delete(0);
            end
          end
          REQ_WIDTH: begin
            start <= 1'b0;
            if (pending_results.size() == 0 && !busy) begin
              cfg_valid <= 1'b1;
              cfg_data <= req_q[0].width;
              width_sent++;
              req_q.delete(0);
            end else begin
              cfg_valid <= 1'b0;
            end
          end
          default: begin
            // hold off until every outstanding result is back
            start <= 1'b0;
            cfg_valid <= 1'b0;
            if (pending_results.size() == 0) req_q.delete(0);
          end
        endcase
      end
    end
  end

  // monitor: check results, then predict for newly accepted beats
  always @(posedge clk) begin : mon
    table_res_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: outcome %0d hit_count %0d", outcome, hit_count);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            err_cnt++;
          end
          if (hit_count !== want.hits) begin
            $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
            err_cnt++;
          end
          if (rank_position !== want.rank) begin
            $error("rank_position: expected %0d, got %0d", want.rank, rank_position);
            err_cnt++;
          end
          if (stored_total !== want.total) begin
            $error("stored_total: expected %0d, got %0d", want.total, stored_total);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        tbl_width = cfg_data;
        width_taken <= width_taken + 1;
      end
      if (start && !busy) begin
        pending_results.push_back(table_insert(energy, solution));
        cand_taken <= cand_taken + 1;
      end
    end
  end

  // watchdog on stretches with no beat and no result
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("top_energy_solution_table_top_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

### sim.f
design/tetab_pkg.sv
design/tetab_cell.sv
design/top_energy_solution_table_top.sv
sim/top_energy_solution_table_top_tb.sv
